// ===== design/psot_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, field offsets, register codes and stage-enable type for the overlap test.
package psot_pkg;

   // Field widths of the input beat and the registers.
   localparam int COORD_WIDTH = 24;
   localparam int BOX_WIDTH   = 23;
   localparam int DIAM_WIDTH  = 23;
   localparam int SCALE_WIDTH = 16;

   // Per-axis difference: (second +/- box) - first, with room for the sign.
   localparam int DIFF_WIDTH = ((COORD_WIDTH > BOX_WIDTH) ? COORD_WIDTH : BOX_WIDTH) + 2;
   localparam int ABS_WIDTH  = DIFF_WIDTH - 1;
   localparam int SQ_WIDTH   = 2 * ABS_WIDTH;
   localparam int R2_WIDTH   = SQ_WIDTH + 2;

   // Threshold: T = scale * (d1 + d2), compared as r2 * 2^26 < T^2.
   localparam int DSUM_WIDTH = DIAM_WIDTH + 1;
   localparam int THR_WIDTH  = SCALE_WIDTH + DSUM_WIDTH;
   localparam int THR_LO     = THR_WIDTH / 2;
   localparam int THR_HI     = THR_WIDTH - THR_LO;
   localparam int TSQ_WIDTH  = 2 * THR_WIDTH;
   localparam int CMP_SHIFT  = 26;
   localparam int CMP_WIDTH  = ((R2_WIDTH + CMP_SHIFT) > TSQ_WIDTH) ?
                               (R2_WIDTH + CMP_SHIFT) : TSQ_WIDTH;

   // Request beat layout, first field in the lowest bits.
   localparam int OFS_FIRST_X   = 0;
   localparam int OFS_FIRST_Y   = OFS_FIRST_X + COORD_WIDTH;
   localparam int OFS_FIRST_Z   = OFS_FIRST_Y + COORD_WIDTH;
   localparam int OFS_FIRST_D   = OFS_FIRST_Z + COORD_WIDTH;
   localparam int OFS_SECOND_X  = OFS_FIRST_D + DIAM_WIDTH;
   localparam int OFS_SECOND_Y  = OFS_SECOND_X + COORD_WIDTH;
   localparam int OFS_SECOND_Z  = OFS_SECOND_Y + COORD_WIDTH;
   localparam int OFS_SECOND_D  = OFS_SECOND_Z + COORD_WIDTH;
   localparam int REQ_BITS      = OFS_SECOND_D + DIAM_WIDTH;
   localparam int REQ_DATA_WIDTH = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH = 8;

   // Configuration port.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = (BOX_WIDTH > SCALE_WIDTH) ? BOX_WIDTH : SCALE_WIDTH;
   localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = SCALE_WIDTH'(4096);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_OVERLAP_SCALE = 2'd0,
      CSR_BOX_SIZE_X    = 2'd1,
      CSR_BOX_SIZE_Y    = 2'd2,
      CSR_BOX_SIZE_Z    = 2'd3
   } psot_csr_type;

   // Load enables of the five pipeline stages.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } psot_stage_en_type;

endpackage

// ===== design/periodic_sphere_overlap_test_unit.sv =====
`timescale 1ns / 1ps
// Top level of the periodic sphere overlap test: ports, registers, pipeline control.
//
//   channel   direction  ports                                   beat
//   req_      in         req_tvalid/req_tready/req_tdata          one sphere pair
//   rsp_      out        rsp_tvalid/rsp_tready/rsp_tdata          one neighbour flag
//   csr_      in         csr_valid/csr_ready/csr_index/csr_data   one register write
//
// Five register stages; an accepted pair moves through stages 1 to 5 and its flag
// shows on rsp_ from the stage 5 register, and one pair enters every cycle while
// the output is taken.
// Each stage holds when it is full and the stage after it cannot move, so a
// stalled rsp_ fills the bubbles first and then drops req_tready.
// Reset clears the valid bits and loads the register defaults; csr_ is always ready.
module periodic_sphere_overlap_test_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   // first_x, first_y, first_z, first_diameter, second_x, second_y, second_z,
   // second_diameter, from bit 0 up, zero filled to whole bytes
   input  logic [psot_pkg::REQ_DATA_WIDTH-1:0]      req_tdata,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // is_neighbour in bit 0, upper bits zero
   output logic [psot_pkg::RSP_DATA_WIDTH-1:0]      rsp_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [psot_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [psot_pkg::CSR_DATA_WIDTH-1:0]      csr_data
);

   logic [psot_pkg::SCALE_WIDTH-1:0] scale_ff;
   logic [psot_pkg::BOX_WIDTH-1:0]   box_x_ff, box_y_ff, box_z_ff;

   logic                             valid1_ff, valid2_ff, valid3_ff, valid4_ff, valid5_ff;
   logic                             adv1, adv2, adv3, adv4, adv5;
   psot_pkg::psot_stage_en_type      stage_en;

   logic [psot_pkg::SQ_WIDTH-1:0]    sq_x, sq_y, sq_z;
   logic [psot_pkg::TSQ_WIDTH-1:0]   thr_sq;
   logic [psot_pkg::R2_WIDTH-1:0]    r2_in, r2_ff;
   logic [psot_pkg::CMP_WIDTH-1:0]   cmp_lhs, cmp_rhs;
   logic                             hit_in, hit_ff;

   // Configuration registers; only the low bits of a write are kept.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= psot_pkg::SCALE_RESET;
         box_x_ff <= '0;
         box_y_ff <= '0;
         box_z_ff <= '0;
      end else if (csr_valid) begin
         unique case (psot_pkg::psot_csr_type'(csr_index))
            psot_pkg::CSR_OVERLAP_SCALE: begin
               scale_ff <= csr_data[psot_pkg::SCALE_WIDTH-1:0];
            end
            psot_pkg::CSR_BOX_SIZE_X: begin
               box_x_ff <= csr_data[psot_pkg::BOX_WIDTH-1:0];
            end
            psot_pkg::CSR_BOX_SIZE_Y: begin
               box_y_ff <= csr_data[psot_pkg::BOX_WIDTH-1:0];
            end
            psot_pkg::CSR_BOX_SIZE_Z: begin
               box_z_ff <= csr_data[psot_pkg::BOX_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Stage advance: a stage loads when it is empty or its content moves on.
   always_comb begin
      adv5 = !valid5_ff || rsp_tready;
      adv4 = !valid4_ff || adv5;
      adv3 = !valid3_ff || adv4;
      adv2 = !valid2_ff || adv3;
      adv1 = !valid1_ff || adv2;
      stage_en.s1 = adv1;
      stage_en.s2 = adv2;
      stage_en.s3 = adv3;
      stage_en.s4 = adv4;
      stage_en.s5 = adv5;
   end

   assign req_tready = adv1;

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else begin
         if (adv1) valid1_ff <= req_tvalid;
         if (adv2) valid2_ff <= valid1_ff;
         if (adv3) valid3_ff <= valid2_ff;
         if (adv4) valid4_ff <= valid3_ff;
         if (adv5) valid5_ff <= valid4_ff;
      end
   end

   // Per-axis nearest image, stages 1 to 3.
   psot_axis_unit axis_x (
      .clock      (clock),
      .stage_en   (stage_en),
      .first_pos  (req_tdata[psot_pkg::OFS_FIRST_X +: psot_pkg::COORD_WIDTH]),
      .second_pos (req_tdata[psot_pkg::OFS_SECOND_X +: psot_pkg::COORD_WIDTH]),
      .box_size   (box_x_ff),
      .dist_sq    (sq_x)
   );

   psot_axis_unit axis_y (
      .clock      (clock),
      .stage_en   (stage_en),
      .first_pos  (req_tdata[psot_pkg::OFS_FIRST_Y +: psot_pkg::COORD_WIDTH]),
      .second_pos (req_tdata[psot_pkg::OFS_SECOND_Y +: psot_pkg::COORD_WIDTH]),
      .box_size   (box_y_ff),
      .dist_sq    (sq_y)
   );

   psot_axis_unit axis_z (
      .clock      (clock),
      .stage_en   (stage_en),
      .first_pos  (req_tdata[psot_pkg::OFS_FIRST_Z +: psot_pkg::COORD_WIDTH]),
      .second_pos (req_tdata[psot_pkg::OFS_SECOND_Z +: psot_pkg::COORD_WIDTH]),
      .box_size   (box_z_ff),
      .dist_sq    (sq_z)
   );

   // Squared threshold, stages 1 to 4.
   psot_threshold_unit thr_unit (
      .clock           (clock),
      .stage_en        (stage_en),
      .first_diameter  (req_tdata[psot_pkg::OFS_FIRST_D +: psot_pkg::DIAM_WIDTH]),
      .second_diameter (req_tdata[psot_pkg::OFS_SECOND_D +: psot_pkg::DIAM_WIDTH]),
      .overlap_scale   (scale_ff),
      .thr_sq          (thr_sq)
   );

   // Stage 4: squared distance of the nearest image.
   assign r2_in = psot_pkg::R2_WIDTH'(sq_x) + psot_pkg::R2_WIDTH'(sq_y)
                + psot_pkg::R2_WIDTH'(sq_z);

   always_ff @(posedge clock) begin
      if (stage_en.s4) begin
         r2_ff <= r2_in;
      end
   end

   // Stage 5: strict compare at full width into the output register.
   always_comb begin
      cmp_lhs = psot_pkg::CMP_WIDTH'({r2_ff, {psot_pkg::CMP_SHIFT{1'b0}}});
      cmp_rhs = psot_pkg::CMP_WIDTH'(thr_sq);
      hit_in  = cmp_lhs < cmp_rhs;
   end

   always_ff @(posedge clock) begin
      if (stage_en.s5) begin
         hit_ff <= hit_in;
      end
   end

   assign rsp_tvalid = valid5_ff;
   assign rsp_tdata  = psot_pkg::RSP_DATA_WIDTH'(hit_ff);

endmodule

// ===== design/psot_axis_unit.sv =====
`timescale 1ns / 1ps
// One axis: nearest periodic image distance, squared, over three stages.
module psot_axis_unit (
   input  logic                                       clock,
   input  psot_pkg::psot_stage_en_type                stage_en,
   input  logic signed [psot_pkg::COORD_WIDTH-1:0]    first_pos,
   input  logic signed [psot_pkg::COORD_WIDTH-1:0]    second_pos,
   input  logic        [psot_pkg::BOX_WIDTH-1:0]      box_size,
   output logic        [psot_pkg::SQ_WIDTH-1:0]       dist_sq
);

   logic signed [psot_pkg::DIFF_WIDTH-1:0] diff_mid;
   logic signed [psot_pkg::DIFF_WIDTH-1:0] diff_lo;
   logic signed [psot_pkg::DIFF_WIDTH-1:0] diff_hi;
   logic signed [psot_pkg::DIFF_WIDTH-1:0] box_ext;
   logic [psot_pkg::ABS_WIDTH-1:0] abs_mid_in, abs_lo_in, abs_hi_in;
   logic [psot_pkg::ABS_WIDTH-1:0] abs_mid_ff, abs_lo_ff, abs_hi_ff;
   logic [psot_pkg::ABS_WIDTH-1:0] min_in, min_ff;
   logic [psot_pkg::ABS_WIDTH-1:0] min_pair;
   logic [psot_pkg::SQ_WIDTH-1:0]  sq_in, sq_ff;

   // Stage 1: differences of the three images along this axis, as magnitudes.
   always_comb begin
      box_ext  = psot_pkg::DIFF_WIDTH'(signed'({1'b0, box_size}));
      diff_mid = psot_pkg::DIFF_WIDTH'(second_pos) - psot_pkg::DIFF_WIDTH'(first_pos);
      diff_lo  = diff_mid - box_ext;
      diff_hi  = diff_mid + box_ext;
      abs_mid_in = diff_mid[psot_pkg::DIFF_WIDTH-1] ?
                   psot_pkg::ABS_WIDTH'(-diff_mid) : psot_pkg::ABS_WIDTH'(diff_mid);
      abs_lo_in  = diff_lo[psot_pkg::DIFF_WIDTH-1] ?
                   psot_pkg::ABS_WIDTH'(-diff_lo) : psot_pkg::ABS_WIDTH'(diff_lo);
      abs_hi_in  = diff_hi[psot_pkg::DIFF_WIDTH-1] ?
                   psot_pkg::ABS_WIDTH'(-diff_hi) : psot_pkg::ABS_WIDTH'(diff_hi);
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         abs_mid_ff <= abs_mid_in;
         abs_lo_ff  <= abs_lo_in;
         abs_hi_ff  <= abs_hi_in;
      end
   end

   // Stage 2: the nearest image; squaring is monotonic, so the smallest magnitude wins.
   always_comb begin
      min_pair = (abs_lo_ff < abs_mid_ff) ? abs_lo_ff : abs_mid_ff;
      min_in   = (abs_hi_ff < min_pair) ? abs_hi_ff : min_pair;
   end

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         min_ff <= min_in;
      end
   end

   // Stage 3: square of the nearest distance.
   assign sq_in = min_ff * min_ff;

   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         sq_ff <= sq_in;
      end
   end

   assign dist_sq = sq_ff;

endmodule

// ===== design/psot_threshold_unit.sv =====
`timescale 1ns / 1ps
// Squared threshold (scale times diameter sum, squared) over four stages.
module psot_threshold_unit (
   input  logic                                  clock,
   input  psot_pkg::psot_stage_en_type           stage_en,
   input  logic [psot_pkg::DIAM_WIDTH-1:0]       first_diameter,
   input  logic [psot_pkg::DIAM_WIDTH-1:0]       second_diameter,
   input  logic [psot_pkg::SCALE_WIDTH-1:0]      overlap_scale,
   output logic [psot_pkg::TSQ_WIDTH-1:0]        thr_sq
);

   logic [psot_pkg::DSUM_WIDTH-1:0]  dsum_in, dsum_ff;
   logic [psot_pkg::THR_WIDTH-1:0]   thr_in, thr_ff;
   logic [psot_pkg::THR_HI-1:0]      thr_hi;
   logic [psot_pkg::THR_LO-1:0]      thr_lo;
   logic [2*psot_pkg::THR_HI-1:0]    pp_hh_in, pp_hh_ff;
   logic [psot_pkg::THR_WIDTH-1:0]   pp_hl_in, pp_hl_ff;
   logic [2*psot_pkg::THR_LO-1:0]    pp_ll_in, pp_ll_ff;
   logic [psot_pkg::TSQ_WIDTH-1:0]   tsq_in, tsq_ff;

   // Stage 1: sum of the diameters.
   assign dsum_in = psot_pkg::DSUM_WIDTH'(first_diameter)
                  + psot_pkg::DSUM_WIDTH'(second_diameter);

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         dsum_ff <= dsum_in;
      end
   end

   // Stage 2: twice the threshold, 12 fraction bits.
   assign thr_in = overlap_scale * dsum_ff;

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         thr_ff <= thr_in;
      end
   end

   // Stage 3: the square split into three half-width partial products.
   always_comb begin
      thr_hi   = thr_ff[psot_pkg::THR_WIDTH-1:psot_pkg::THR_LO];
      thr_lo   = thr_ff[psot_pkg::THR_LO-1:0];
      pp_hh_in = thr_hi * thr_hi;
      pp_hl_in = thr_hi * thr_lo;
      pp_ll_in = thr_lo * thr_lo;
   end

   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         pp_hh_ff <= pp_hh_in;
         pp_hl_ff <= pp_hl_in;
         pp_ll_ff <= pp_ll_in;
      end
   end

   // Stage 4: hh and ll do not overlap; the cross term counts twice.
   assign tsq_in = {pp_hh_ff, pp_ll_ff}
                 + (psot_pkg::TSQ_WIDTH'(pp_hl_ff) << (psot_pkg::THR_LO + 1));

   always_ff @(posedge clock) begin
      if (stage_en.s4) begin
         tsq_ff <= tsq_in;
      end
   end

   assign thr_sq = tsq_ff;

endmodule

// ===== bench/periodic_sphere_overlap_test_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the periodic sphere overlap test: random and edge-case pairs.
module periodic_sphere_overlap_test_unit_test;

   typedef logic signed [psot_pkg::COORD_WIDTH-1:0] coord_type;
   typedef logic [psot_pkg::DIAM_WIDTH-1:0]         diam_type;

   typedef struct {
      coord_type first_x;
      coord_type first_y;
      coord_type first_z;
      diam_type  first_diameter;
      coord_type second_x;
      coord_type second_y;
      coord_type second_z;
      diam_type  second_diameter;
   } sphere_pair_type;

   localparam int COORD_MAX   = 2**(psot_pkg::COORD_WIDTH-1) - 1;
   localparam int COORD_MIN   = -(2**(psot_pkg::COORD_WIDTH-1));
   localparam int DIAM_MAX    = 2**psot_pkg::DIAM_WIDTH - 1;
   localparam int BOX_MAX     = 2**psot_pkg::BOX_WIDTH - 1;
   localparam int DRAIN_CYCLES = 20;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic [psot_pkg::REQ_DATA_WIDTH-1:0]  req_tdata = '0;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [psot_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [psot_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [psot_pkg::CSR_DATA_WIDTH-1:0]  csr_data = '0;

   // Bench copy of the configuration registers.
   logic [psot_pkg::SCALE_WIDTH-1:0] scale_setting = psot_pkg::SCALE_RESET;
   logic [psot_pkg::BOX_WIDTH-1:0]   box_x_setting = '0;
   logic [psot_pkg::BOX_WIDTH-1:0]   box_y_setting = '0;
   logic [psot_pkg::BOX_WIDTH-1:0]   box_z_setting = '0;

   sphere_pair_type pairs_to_send[$];
   bit              expected_flags[$];
   sphere_pair_type pair_on_bus;
   bit              beat_waiting = 1'b0;
   bit              idle_on = 1'b1;
   bit              wanted_flag;
   int              gap_left = 0;
   int              stall_left = 0;
   int              pairs_accepted = 0;
   int              flags_checked = 0;
   int              neighbours_seen = 0;
   int              mismatch_count = 0;
   int              settings_used = 1;

   periodic_sphere_overlap_test_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // Exact neighbour decision over all 27 images of the second sphere.
   function automatic bit neighbour_flag(sphere_pair_type p);
      logic [127:0] reach_sq;
      logic [127:0] dist_sq;
      longint       dx, dy, dz;
      bit           hit;
      hit = 1'b0;
      reach_sq = 128'(scale_setting) * (128'(p.first_diameter) + 128'(p.second_diameter));
      reach_sq = reach_sq * reach_sq;
      for (int a = -1; a <= 1; a++) begin
         dx = longint'(p.second_x) + a * longint'(box_x_setting) - longint'(p.first_x);
         for (int b = -1; b <= 1; b++) begin
            dy = longint'(p.second_y) + b * longint'(box_y_setting) - longint'(p.first_y);
            for (int c = -1; c <= 1; c++) begin
               dz = longint'(p.second_z) + c * longint'(box_z_setting) - longint'(p.first_z);
               dist_sq = 128'(dx * dx) + 128'(dy * dy) + 128'(dz * dz);
               if ((dist_sq << 26) < reach_sq) hit = 1'b1;
            end
         end
      end
      return hit;
   endfunction

   function automatic sphere_pair_type make_pair(int fx, int fy, int fz, int fd,
                                                 int sx, int sy, int sz, int sd);
      sphere_pair_type p;
      p.first_x = coord_type'(fx);
      p.first_y = coord_type'(fy);
      p.first_z = coord_type'(fz);
      p.first_diameter = diam_type'(fd);
      p.second_x = coord_type'(sx);
      p.second_y = coord_type'(sy);
      p.second_z = coord_type'(sz);
      p.second_diameter = diam_type'(sd);
      return p;
   endfunction

   // Mostly short gaps, now and then a long one; none while idle_on is clear.
   function automatic int idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_on || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic diam_type random_diameter();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return diam_type'($urandom);
      return diam_type'($urandom_range(0, 1 << $urandom_range(4, 18)));
   endfunction

   function automatic longint jitter(longint span);
      return longint'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic logic [psot_pkg::CSR_DATA_WIDTH-1:0] random_box();
      return psot_pkg::CSR_DATA_WIDTH'($urandom &
                                       ((1 << $urandom_range(4, psot_pkg::BOX_WIDTH)) - 1));
   endfunction

   // Most pairs sit near each other, near an image, or right at the threshold;
   // a quarter are fully random bit patterns.
   function automatic sphere_pair_type random_pair();
      sphere_pair_type p;
      int              kind;
      longint          reach, span, shift_x, shift_y, shift_z, dx, dy, dz;
      kind = $urandom_range(0, 99);
      p.first_x = coord_type'($urandom);
      p.first_y = coord_type'($urandom);
      p.first_z = coord_type'($urandom);
      if (kind < 25) begin
         p.first_diameter = diam_type'($urandom);
         p.second_x = coord_type'($urandom);
         p.second_y = coord_type'($urandom);
         p.second_z = coord_type'($urandom);
         p.second_diameter = diam_type'($urandom);
         return p;
      end
      p.first_diameter = random_diameter();
      p.second_diameter = random_diameter();
      reach = (longint'(scale_setting) *
               (longint'(p.first_diameter) + longint'(p.second_diameter))) >>> 13;
      span = (reach + 16 > (1 << 22)) ? (1 << 22) : reach + 16;
      shift_x = 0;
      shift_y = 0;
      shift_z = 0;
      if (kind >= 60) begin
         shift_x = longint'(box_x_setting) * (int'($urandom_range(0, 2)) - 1);
         shift_y = longint'(box_y_setting) * (int'($urandom_range(0, 2)) - 1);
         shift_z = longint'(box_z_setting) * (int'($urandom_range(0, 2)) - 1);
      end
      if (kind >= 85) begin
         // Distance along x within a couple of LSBs of the threshold.
         dx = reach + int'($urandom_range(0, 4)) - 2;
         if ($urandom_range(0, 1)) dx = -dx;
         dy = 0;
         dz = 0;
      end else begin
         dx = jitter(span);
         dy = jitter(span);
         dz = jitter(span);
      end
      p.second_x = coord_type'(longint'(p.first_x) + shift_x + dx);
      p.second_y = coord_type'(longint'(p.first_y) + shift_y + dy);
      p.second_z = coord_type'(longint'(p.first_z) + shift_z + dz);
      return p;
   endfunction

   // Request driver: one pair per beat, random gaps between beats.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_flags.push_back(neighbour_flag(pair_on_bus));
            pairs_accepted++;
            beat_waiting = 1'b0;
            gap_left = idle_cycles();
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pairs_to_send.size() != 0) begin
               pair_on_bus = pairs_to_send.pop_front();
               beat_waiting = 1'b1;
               req_tdata <= psot_pkg::REQ_DATA_WIDTH'({pair_on_bus.second_diameter,
                                                       pair_on_bus.second_z,
                                                       pair_on_bus.second_y,
                                                       pair_on_bus.second_x,
                                                       pair_on_bus.first_diameter,
                                                       pair_on_bus.first_z,
                                                       pair_on_bus.first_y,
                                                       pair_on_bus.first_x});
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each flag against the oldest prediction and stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_flags.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Unexpected result beat with is_neighbour %0b", rsp_tdata[0]);
            end else begin
               wanted_flag = expected_flags.pop_front();
               if (wanted_flag) neighbours_seen++;
               if (rsp_tdata[0] !== wanted_flag) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("Result %0d: is_neighbour expected %0b, got %0b",
                              flags_checked, wanted_flag, rsp_tdata[0]);
               end
               flags_checked++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = ($urandom_range(0, 7) == 0) ? idle_cycles() : 0;
         end
      end
   end

   // One register write; the bench copy keeps only the register's own width.
   task automatic write_setting(psot_pkg::psot_csr_type index,
                                logic [psot_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         psot_pkg::CSR_OVERLAP_SCALE: scale_setting = value[psot_pkg::SCALE_WIDTH-1:0];
         psot_pkg::CSR_BOX_SIZE_X: box_x_setting = value[psot_pkg::BOX_WIDTH-1:0];
         psot_pkg::CSR_BOX_SIZE_Y: box_y_setting = value[psot_pkg::BOX_WIDTH-1:0];
         psot_pkg::CSR_BOX_SIZE_Z: box_z_setting = value[psot_pkg::BOX_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(logic [psot_pkg::CSR_DATA_WIDTH-1:0] scale,
                                 logic [psot_pkg::CSR_DATA_WIDTH-1:0] box_x,
                                 logic [psot_pkg::CSR_DATA_WIDTH-1:0] box_y,
                                 logic [psot_pkg::CSR_DATA_WIDTH-1:0] box_z);
      write_setting(psot_pkg::CSR_OVERLAP_SCALE, scale);
      write_setting(psot_pkg::CSR_BOX_SIZE_X, box_x);
      write_setting(psot_pkg::CSR_BOX_SIZE_Y, box_y);
      write_setting(psot_pkg::CSR_BOX_SIZE_Z, box_z);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic queue_random_pairs(int count);
      repeat (count) pairs_to_send.push_back(random_pair());
   endtask

   // Waits until every queued pair has been accepted and every flag has come back.
   task automatic wait_until_idle();
      do @(posedge clock);
      while (pairs_to_send.size() != 0 || beat_waiting || req_tvalid ||
             expected_flags.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Stimulus sequence: one phase per register setting.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: unit scale, zero box, so only the direct image counts.
      pairs_to_send.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
      pairs_to_send.push_back(make_pair(0, 0, 0, 1, 0, 0, 0, 0));
      pairs_to_send.push_back(make_pair(COORD_MIN, COORD_MIN, COORD_MIN, DIAM_MAX,
                                        COORD_MAX, COORD_MAX, COORD_MAX, DIAM_MAX));
      pairs_to_send.push_back(make_pair(COORD_MAX, COORD_MAX, COORD_MAX, DIAM_MAX,
                                        COORD_MAX, COORD_MAX, COORD_MAX, DIAM_MAX));
      // Exactly touching is not a neighbour; one LSB closer is.
      pairs_to_send.push_back(make_pair(0, 0, 0, 8192, 8192, 0, 0, 8192));
      pairs_to_send.push_back(make_pair(0, 0, 0, 8192, 8191, 0, 0, 8192));
      pairs_to_send.push_back(make_pair(0, 0, 0, 8192, 0, 0, -8192, 8192));
      pairs_to_send.push_back(make_pair(0, 0, 0, 8192, 0, 0, -8191, 8192));
      pairs_to_send.push_back(make_pair(COORD_MIN, 0, 0, 4096, COORD_MAX, 0, 0, 4096));
      queue_random_pairs(50);
      wait_until_idle();

      // Largest scale, written with all data bits set, and largest boxes.
      apply_settings({psot_pkg::CSR_DATA_WIDTH{1'b1}},
                     psot_pkg::CSR_DATA_WIDTH'(BOX_MAX),
                     psot_pkg::CSR_DATA_WIDTH'(BOX_MAX),
                     psot_pkg::CSR_DATA_WIDTH'(BOX_MAX));
      pairs_to_send.push_back(make_pair(-4000000, -4000000, -4000000, 1,
                                        -4000000 + BOX_MAX, -4000000 + BOX_MAX,
                                        -4000000 + BOX_MAX, 1));
      pairs_to_send.push_back(make_pair(4000000, 4000000, 4000000, 1,
                                        4000000 - BOX_MAX, 4000000 - BOX_MAX,
                                        4000000 - BOX_MAX, 1));
      pairs_to_send.push_back(make_pair(COORD_MIN, COORD_MIN, COORD_MIN, DIAM_MAX,
                                        COORD_MAX, COORD_MAX, COORD_MAX, DIAM_MAX));
      pairs_to_send.push_back(make_pair(0, 0, 0, 0, 5, 5, 5, 0));
      queue_random_pairs(70);
      wait_until_idle();

      // Zero scale never gives a neighbour; this phase runs without gaps or stalls.
      idle_on = 1'b0;
      apply_settings('0, random_box(), random_box(), random_box());
      pairs_to_send.push_back(make_pair(0, 0, 0, DIAM_MAX, 0, 0, 0, DIAM_MAX));
      queue_random_pairs(50);
      wait_until_idle();
      idle_on = 1'b1;

      apply_settings(psot_pkg::CSR_DATA_WIDTH'(4096), psot_pkg::CSR_DATA_WIDTH'(40960),
                     '0, random_box());
      queue_random_pairs(80);
      wait_until_idle();

      apply_settings(psot_pkg::CSR_DATA_WIDTH'($urandom_range(0, 2**psot_pkg::SCALE_WIDTH - 1)),
                     random_box(), random_box(), random_box());
      queue_random_pairs(80);
      wait_until_idle();

      apply_settings(psot_pkg::CSR_DATA_WIDTH'(2048), random_box(), random_box(),
                     random_box());
      queue_random_pairs(70);
      wait_until_idle();

      $display("Sent %0d and checked %0d sphere pairs (%0d neighbours) under %0d settings.",
               pairs_accepted, flags_checked, neighbours_seen, settings_used);
      $display("Mismatches found: %0d", mismatch_count);
      if (mismatch_count == 0 && expected_flags.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Hard stop in case the block hangs.
   initial begin
      #5000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
design/psot_pkg.sv
design/psot_axis_unit.sv
design/psot_threshold_unit.sv
design/periodic_sphere_overlap_test_unit.sv
bench/periodic_sphere_overlap_test_unit_test.sv
